/* sv/elliptic_fourier_reconstruction_assert.svh */
// Assertion macros for the elliptic Fourier reconstruction block.
// Used by modules that have clk and arst_n in scope.
`ifndef ELLIPTIC_FOURIER_RECONSTRUCTION_ASSERT_SVH
`define ELLIPTIC_FOURIER_RECONSTRUCTION_ASSERT_SVH

// same-cycle implication
`define EFR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/efr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the sine table generator.
// No dependencies.
package efr_pkg;

	localparam int DEF_MAX_HARMONICS   = 8;
	localparam int DEF_MAX_POINTS      = 64;
	localparam int DEF_SINE_TABLE_BITS = 10;

	localparam int COEF_W = 32;
	localparam int TRIG_W = 31;
	localparam int PIDX_W = 6;
	localparam int PCNT_W = 7;
	localparam int HCNT_W = 4;
	localparam int DIV_W  = 6;
	localparam int HSEL_W = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 1'd1;

	localparam logic [HCNT_W-1:0] HCNT_RESET = 4'd8;
	localparam logic [PCNT_W-1:0] PCNT_RESET = 7'd12;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned ONE_Q30    = 64'd1073741824;
	localparam longint unsigned SIN_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

	typedef struct packed {
		logic              valid;
		logic [PIDX_W-1:0] k;
		logic              last;
	} ctl_t;

	// quarter-turn sine in Q1.30, Taylor series to x^11
	function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned q,
		input int unsigned bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          s;
		x = (longint'(q) * TWO_PI_Q30 + (64'd1 << (bits - 1))) >> bits;
		x2 = (x * x) >> 30;
		term = x;
		s = longint'(x);
		for (int j = 1; j <= 5; j++) begin
			term = ((term * x2) >> 30) / SIN_DIV[j-1];
			if (j % 2 == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		if (s < 0) s = 0;
		if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
		return TRIG_W'(s);
	endfunction

endpackage

/* sv/efr_row_if.sv */
`timescale 1ns / 1ps
// Request channel carrying one coefficient row.
// Depends on efr_pkg.
interface efr_row_if;
	import efr_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [2:0]               row_index;
	logic signed [COEF_W-1:0] x_cos_coef;
	logic signed [COEF_W-1:0] x_sin_coef;
	logic signed [COEF_W-1:0] y_cos_coef;
	logic signed [COEF_W-1:0] y_sin_coef;
	logic signed [COEF_W-1:0] z_cos_coef;
	logic signed [COEF_W-1:0] z_sin_coef;
	logic signed [COEF_W-1:0] locus_x;
	logic signed [COEF_W-1:0] locus_y;
	logic signed [COEF_W-1:0] locus_z;
	logic                     last_row;

	modport source (output valid, row_index, x_cos_coef, x_sin_coef, y_cos_coef,
		y_sin_coef, z_cos_coef, z_sin_coef, locus_x, locus_y, locus_z, last_row,
		input ready);
	modport sink (input valid, row_index, x_cos_coef, x_sin_coef, y_cos_coef,
		y_sin_coef, z_cos_coef, z_sin_coef, locus_x, locus_y, locus_z, last_row,
		output ready);
endinterface

/* sv/efr_point_if.sv */
`timescale 1ns / 1ps
// Request channel carrying one reconstructed point.
// Depends on efr_pkg.
interface efr_point_if;
	import efr_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [PIDX_W-1:0]        point_index;
	logic signed [COEF_W-1:0] point_x;
	logic signed [COEF_W-1:0] point_y;
	logic signed [COEF_W-1:0] point_z;
	logic                     last_point;

	modport source (output valid, point_index, point_x, point_y, point_z, last_point,
		input ready);
	modport sink (input valid, point_index, point_x, point_y, point_z, last_point,
		output ready);
endinterface

/* sv/efr_cell.sv */
`timescale 1ns / 1ps
// One harmonic cell: holds a coefficient row, adds its term to a passing point.
// Depends on efr_pkg.
module efr_cell #(
	parameter int CELL_IDX        = 0,
	parameter int SINE_TABLE_BITS = efr_pkg::DEF_SINE_TABLE_BITS,
	parameter int ACC_W           = 40
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic                                     wr_row,
	input  logic signed [efr_pkg::COEF_W-1:0]        coef_i [6],
	input  logic [efr_pkg::HSEL_W-1:0]               h,
	input  logic [efr_pkg::DIV_W-1:0]                d,
	input  efr_pkg::ctl_t                            ctl_i,
	input  logic [SINE_TABLE_BITS-1:0]               q_i,
	input  logic [efr_pkg::DIV_W-1:0]                r_i,
	input  logic [SINE_TABLE_BITS-1:0]               qs_i,
	input  logic [efr_pkg::DIV_W-1:0]                rs_i,
	input  logic signed [ACC_W-1:0]                  acc_i [3],
	output efr_pkg::ctl_t                            ctl_o,
	output logic [SINE_TABLE_BITS-1:0]               q_o,
	output logic [efr_pkg::DIV_W-1:0]                r_o,
	output logic [SINE_TABLE_BITS-1:0]               qs_o,
	output logic [efr_pkg::DIV_W-1:0]                rs_o,
	output logic signed [ACC_W-1:0]                  acc_o [3],
	output logic                                     busy
);
	import efr_pkg::*;

	localparam int B   = SINE_TABLE_BITS;
	localparam int QTR = 1 << (B - 2);
	localparam logic signed [63:0] RND = 64'sd536870912;

	typedef logic [TRIG_W-1:0] rom_t [QTR+1];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i <= QTR; i++) r[i] = quarter_sine(i, B);
		return r;
	endfunction

	localparam rom_t SIN_ROM = build_rom();

	logic signed [COEF_W-1:0] coef_q [6];

	// quadrant folding of sine and cosine indices, and the next harmonic's phase
	logic [B-1:0] qc;
	logic [B-2:0] s_addr, c_addr;
	logic [DIV_W:0] rsum;
	logic         rwrap;
	logic [B-1:0] q_nx;
	logic [DIV_W-1:0] r_nx;

	always_comb begin
		qc = q_i + B'(QTR);
		s_addr = q_i[B-2] ? (B-1)'(QTR) - {1'b0, q_i[B-3:0]} : {1'b0, q_i[B-3:0]};
		c_addr = qc[B-2] ? (B-1)'(QTR) - {1'b0, qc[B-3:0]} : {1'b0, qc[B-3:0]};
		rsum = {1'b0, r_i} + {1'b0, rs_i};
		rwrap = rsum >= {1'b0, d};
		r_nx = rwrap ? DIV_W'(rsum - {1'b0, d}) : DIV_W'(rsum);
		q_nx = q_i + qs_i + B'(rwrap);
	end

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [TRIG_W-1:0] smag_s1, cmag_s1;
	logic sneg_s1, cneg_s1;
	logic [B-1:0] q_s1, q_s2, q_s3, qs_s1, qs_s2, qs_s3;
	logic [DIV_W-1:0] r_s1, r_s2, r_s3, rs_s1, rs_s2, rs_s3;
	logic signed [ACC_W-1:0] acc_s1 [3], acc_s2 [3], acc_s3 [3];
	logic signed [63:0] pc_s2 [3], ps_s2 [3];
	logic active_s2;

	logic signed [COEF_W-1:0] sin_v, cos_v;
	always_comb begin
		sin_v = sneg_s1 ? -$signed({1'b0, smag_s1}) : $signed({1'b0, smag_s1});
		cos_v = cneg_s1 ? -$signed({1'b0, cmag_s1}) : $signed({1'b0, cmag_s1});
	end

	logic signed [63:0] tc [3], ts [3];
	logic signed [ACC_W-1:0] acc_nx [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			tc[a] = (pc_s2[a] + RND) >>> 30;
			ts[a] = (ps_s2[a] + RND) >>> 30;
			acc_nx[a] = active_s2
				? acc_s2[a] + ACC_W'($signed(tc[a][33:0])) + ACC_W'($signed(ts[a][33:0]))
				: acc_s2[a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_row) begin
			for (int i = 0; i < 6; i++) coef_q[i] <= coef_i[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: table read, next harmonic's phase
			smag_s1 <= SIN_ROM[s_addr];
			cmag_s1 <= SIN_ROM[c_addr];
			sneg_s1 <= q_i[B-1];
			cneg_s1 <= qc[B-1];
			q_s1 <= q_nx;
			r_s1 <= r_nx;
			qs_s1 <= qs_i;
			rs_s1 <= rs_i;
			acc_s1 <= acc_i;
			// s2: products
			for (int a = 0; a < 3; a++) begin
				pc_s2[a] <= coef_q[2*a] * cos_v;
				ps_s2[a] <= coef_q[2*a+1] * sin_v;
			end
			active_s2 <= h > HSEL_W'(CELL_IDX);
			q_s2 <= q_s1;
			r_s2 <= r_s1;
			qs_s2 <= qs_s1;
			rs_s2 <= rs_s1;
			acc_s2 <= acc_s1;
			// s3: accumulate
			acc_s3 <= acc_nx;
			q_s3 <= q_s2;
			r_s3 <= r_s2;
			qs_s3 <= qs_s2;
			rs_s3 <= rs_s2;
		end
	end

	assign ctl_o = ctl_s3;
	assign q_o   = q_s3;
	assign r_o   = r_s3;
	assign qs_o  = qs_s3;
	assign rs_o  = rs_s3;
	assign acc_o = acc_s3;
	assign busy  = ctl_s1.valid | ctl_s2.valid | ctl_s3.valid;

endmodule

/* sv/elliptic_fourier_reconstruction.sv */
`timescale 1ns / 1ps
// Top level: configuration, point sequencer, chain of harmonic cells, output register.
// Depends on efr_pkg, efr_row_if, efr_point_if, efr_cell and the assertion header.
//
//  channel  | dir | handshake     | carries
//  rows     | in  | valid / ready | one harmonic row, locus on the last row
//  points   | out | valid / ready | one reconstructed point per request
//  wr_*     | in  | wr_en only    | harmonic_count, point_count
//
// The last row starts the phase-step division, then one point enters the cell chain per
// cycle unless points stalls the chain; each point crosses 3*MAX_HARMONICS register
// stages. rows is not ready until the chain has drained.
// Reset is asynchronous; a stalled points request freezes the whole chain.
module elliptic_fourier_reconstruction #(
	parameter int MAX_HARMONICS   = efr_pkg::DEF_MAX_HARMONICS,
	parameter int MAX_POINTS      = efr_pkg::DEF_MAX_POINTS,
	parameter int SINE_TABLE_BITS = efr_pkg::DEF_SINE_TABLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [efr_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [efr_pkg::CFG_DATA_W-1:0]     wr_data,
	efr_row_if.sink                            rows,
	efr_point_if.source                        points
);
	import efr_pkg::*;
	`include "elliptic_fourier_reconstruction_assert.svh"

	localparam int B     = SINE_TABLE_BITS;
	localparam int ACC_W = 34 + $clog2(2 * MAX_HARMONICS + 1);
	localparam int CNT_W = $clog2(B + 1);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_RUN} state_t;

	// configuration registers
	logic [HCNT_W-1:0] hc_q;
	logic [PCNT_W-1:0] pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= HCNT_RESET;
			pc_q <= PCNT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_HARMONIC_COUNT: hc_q <= wr_data[HCNT_W-1:0];
				CFG_POINT_COUNT:    pc_q <= wr_data[PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t state_q;
	logic [HSEL_W-1:0] h_q;
	logic [PCNT_W-1:0] p_q;
	logic [DIV_W-1:0]  d_q, half_q, rb_q, rs_q;
	logic [B-1:0]      qb_q, qs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PIDX_W-1:0] k_q;
	logic signed [COEF_W-1:0] locus_q [3];

	logic chain_busy, adv, row_acc, inject;
	logic [PCNT_W-1:0] k_ext;
	logic [HSEL_W-1:0] h_clamp;
	logic [PCNT_W-1:0] p_clamp;
	logic [DIV_W:0]    div_rem;
	logic              div_bit;
	logic [DIV_W:0]    ini_sum, stp_sum;
	logic              ini_wrap, stp_wrap;

	assign k_ext   = PCNT_W'(k_q);
	assign row_acc = rows.valid && rows.ready;
	assign rows.ready = (state_q == S_IDLE) && !chain_busy;
	assign inject  = (state_q == S_RUN) && adv;

	always_comb begin
		h_clamp = (HSEL_W'(hc_q) > HSEL_W'(MAX_HARMONICS)) ? HSEL_W'(MAX_HARMONICS)
			: HSEL_W'(hc_q);
		p_clamp = (pc_q > PCNT_W'(MAX_POINTS)) ? PCNT_W'(MAX_POINTS) : pc_q;
		// restoring division of the table size by d
		div_rem = {d_q == d_q ? rb_q : rb_q, (cnt_q == CNT_W'(B))};
		div_bit = div_rem >= {1'b0, d_q};
		// first harmonic phase: (k*size + d/2) / d
		ini_sum  = {1'b0, rs_q} + {1'b0, half_q};
		ini_wrap = ini_sum >= {1'b0, d_q};
		// phase step for the next point
		stp_sum  = {1'b0, rs_q} + {1'b0, rb_q};
		stp_wrap = stp_sum >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q <= '0;
			p_q <= '0;
			d_q <= 6'd1;
			half_q <= '0;
			rb_q <= '0;
			qb_q <= '0;
			rs_q <= '0;
			qs_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
			for (int a = 0; a < 3; a++) locus_q[a] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (row_acc && rows.last_row) begin
						locus_q[0] <= rows.locus_x;
						locus_q[1] <= rows.locus_y;
						locus_q[2] <= rows.locus_z;
						h_q <= h_clamp;
						p_q <= p_clamp;
						// single point: divide by one, every phase is zero
						d_q <= (p_clamp > 7'd1) ? DIV_W'(p_clamp - 7'd1) : 6'd1;
						half_q <= (p_clamp > 7'd1) ? DIV_W'((p_clamp - 7'd1) >> 1) : 6'd0;
						rb_q <= '0;
						qb_q <= '0;
						cnt_q <= CNT_W'(B);
						if (p_clamp != '0) state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rb_q <= div_bit ? DIV_W'(div_rem - {1'b0, d_q}) : DIV_W'(div_rem);
					qb_q <= {qb_q[B-2:0], div_bit};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_RUN;
						k_q <= '0;
						qs_q <= '0;
						rs_q <= '0;
					end
				end
				S_RUN: begin
					if (inject) begin
						k_q <= k_q + PIDX_W'(1);
						rs_q <= stp_wrap ? DIV_W'(stp_sum - {1'b0, d_q}) : DIV_W'(stp_sum);
						qs_q <= qs_q + qb_q + B'(stp_wrap);
						if (k_ext == p_q - 7'd1) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// cell chain
	ctl_t ctl_c [MAX_HARMONICS+1];
	logic [B-1:0] q_c [MAX_HARMONICS+1], qs_c [MAX_HARMONICS+1];
	logic [DIV_W-1:0] r_c [MAX_HARMONICS+1], rs_c [MAX_HARMONICS+1];
	logic signed [ACC_W-1:0] acc_c [MAX_HARMONICS+1][3];
	logic [MAX_HARMONICS-1:0] cell_busy;
	logic signed [COEF_W-1:0] coef_in [6];

	assign coef_in[0] = rows.x_cos_coef;
	assign coef_in[1] = rows.x_sin_coef;
	assign coef_in[2] = rows.y_cos_coef;
	assign coef_in[3] = rows.y_sin_coef;
	assign coef_in[4] = rows.z_cos_coef;
	assign coef_in[5] = rows.z_sin_coef;

	always_comb begin
		ctl_c[0].valid = inject;
		ctl_c[0].k     = k_q;
		ctl_c[0].last  = k_ext == p_q - 7'd1;
		q_c[0]  = qs_q + B'(ini_wrap);
		r_c[0]  = ini_wrap ? DIV_W'(ini_sum - {1'b0, d_q}) : DIV_W'(ini_sum);
		qs_c[0] = qs_q;
		rs_c[0] = rs_q;
		for (int a = 0; a < 3; a++) acc_c[0][a] = ACC_W'(locus_q[a]);
	end

	assign chain_busy = |cell_busy;

	for (genvar i = 0; i < MAX_HARMONICS; i++) begin : g_cell
		logic wr_row;
		assign wr_row = row_acc && (HSEL_W'(rows.row_index) == HSEL_W'(i));
		efr_cell #(
			.CELL_IDX(i),
			.SINE_TABLE_BITS(B),
			.ACC_W(ACC_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv), .wr_row(wr_row), .coef_i(coef_in),
			.h(h_q), .d(d_q),
			.ctl_i(ctl_c[i]), .q_i(q_c[i]), .r_i(r_c[i]), .qs_i(qs_c[i]), .rs_i(rs_c[i]),
			.acc_i(acc_c[i]),
			.ctl_o(ctl_c[i+1]), .q_o(q_c[i+1]), .r_o(r_c[i+1]), .qs_o(qs_c[i+1]),
			.rs_o(rs_c[i+1]), .acc_o(acc_c[i+1]), .busy(cell_busy[i])
		);
	end

	// output register with saturation
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

	logic out_valid_q, out_last_q;
	logic [PIDX_W-1:0] out_idx_q;
	logic signed [COEF_W-1:0] out_xyz_q [3];
	ctl_t ctl_end;

	assign ctl_end = ctl_c[MAX_HARMONICS];
	assign adv = !out_valid_q || points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= ctl_end.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q <= ctl_end.k;
			out_last_q <= ctl_end.last;
			for (int a = 0; a < 3; a++) begin
				if (acc_c[MAX_HARMONICS][a] > SAT_HI) out_xyz_q[a] <= 32'sh7fffffff;
				else if (acc_c[MAX_HARMONICS][a] < SAT_LO) out_xyz_q[a] <= 32'sh80000000;
				else out_xyz_q[a] <= COEF_W'(acc_c[MAX_HARMONICS][a]);
			end
		end
	end

	assign points.valid       = out_valid_q;
	assign points.point_index = out_idx_q;
	assign points.point_x     = out_xyz_q[0];
	assign points.point_y     = out_xyz_q[1];
	assign points.point_z     = out_xyz_q[2];
	assign points.last_point  = out_last_q;

	`EFR_ASSERT_SAME(a_k_in_range, state_q == S_RUN, k_ext < p_q, "point counter past count")
	`EFR_ASSERT_NEXT(a_run_ends, inject && (k_ext == p_q - 7'd1), state_q == S_IDLE, "sequencer overran")
	`EFR_ASSERT_SAME(a_div_drained, state_q == S_DIV, !chain_busy, "chain busy during division")
	`EFR_ASSERT_SAME(a_stall_holds, !adv, !inject, "point injected into stalled chain")

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for elliptic_fourier_reconstruction: directed rows, then random shapes.
// Depends on efr_pkg, efr_row_if, efr_point_if and the block itself.
module tb;
	import efr_pkg::*;

	localparam int NHARM  = 8;
	localparam int NPTS   = 64;
	localparam int TBITS  = 10;
	localparam int TSIZE  = 1 << TBITS;
	localparam int QSIZE  = TSIZE / 4;
	// drain allowance: phase-step division, longest shape, cell chain, output register
	localparam int DRAIN  = 128;
	localparam int NITEMS = 450;

	typedef struct packed {
		logic [2:0]               idx;
		logic [5:0][COEF_W-1:0]   coef;   // x cos, x sin, y cos, y sin, z cos, z sin
		logic [2:0][COEF_W-1:0]   loc;    // x, y, z
		logic                     last;
	} row_t;

	typedef struct packed {
		logic [PIDX_W-1:0]        idx;
		logic signed [COEF_W-1:0] x;
		logic signed [COEF_W-1:0] y;
		logic signed [COEF_W-1:0] z;
		logic                     last;
	} point_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	efr_row_if   rows ();
	efr_point_if points ();

	elliptic_fourier_reconstruction dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.rows     (rows.sink),
		.points   (points.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bench copy of the block state
	logic signed [COEF_W-1:0] coef_mem [NHARM][6];
	logic signed [COEF_W-1:0] locus_mem [3];
	logic [HCNT_W-1:0]        harm_cfg;
	logic [PCNT_W-1:0]        pts_cfg;
	longint                   quarter_tbl [QSIZE+1];

	point_t pending_points [$];
	int     errors;
	int     points_seen;
	int     shapes_sent;
	bit     src_calm;
	bit     sink_calm;

	// quarter-turn sine, Q2.30, Taylor series to the x^11 term, clamped to [0, 1]
	function automatic longint quarter_sin_q30(input int unsigned q);
		longint unsigned ang, ang2, term;
		longint          acc;
		ang  = (longint'(q) * TWO_PI_Q30 + (64'd1 << (TBITS - 1))) >> TBITS;
		ang2 = (ang * ang) >> 30;
		term = ang;
		acc  = longint'(ang);
		for (int j = 1; j <= 5; j++) begin
			term = ((term * ang2) >> 30) / longint'((2 * j) * (2 * j + 1));
			if (j % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
		return acc;
	endfunction

	function automatic longint trig_at(input longint unsigned phase);
		int unsigned i, quad, r;
		longint      v;
		i    = int'(phase % TSIZE);
		quad = i / QSIZE;
		r    = i % QSIZE;
		v    = quad[0] ? quarter_tbl[QSIZE - r] : quarter_tbl[r];
		return quad[1] ? -v : v;
	endfunction

	// Q18.46 product back to Q16.16, half up
	function automatic longint round_prod(input longint prod);
		return (prod + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [COEF_W-1:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[COEF_W-1:0];
	endfunction

	// append one expected point behind those already waiting
	task automatic queue_point(input point_t pt);
		pending_points.insert(pending_points.size(), pt);
	endtask

	// expected points of one shape, from the current store and settings
	task automatic reconstruct_shape();
		int unsigned     nh, np, div;
		longint unsigned phase;
		longint          s, c;
		longint          acc [3];
		point_t          pt;
		nh  = (harm_cfg > NHARM) ? NHARM : harm_cfg;
		np  = (pts_cfg > NPTS) ? NPTS : pts_cfg;
		div = (np > 0) ? np - 1 : 0;
		for (int unsigned k = 0; k < np; k++) begin
			for (int a = 0; a < 3; a++) acc[a] = locus_mem[a];
			for (int unsigned n = 0; n < nh; n++) begin
				phase = 0;
				if (div > 0)
					phase = ((longint'((n + 1) * k) << TBITS) + div / 2) / div;
				s = trig_at(phase);
				c = trig_at(phase + QSIZE);
				for (int a = 0; a < 3; a++)
					acc[a] += round_prod(longint'(coef_mem[n][2*a]) * c)
						+ round_prod(longint'(coef_mem[n][2*a+1]) * s);
			end
			pt.idx  = k[PIDX_W-1:0];
			pt.x    = clip32(acc[0]);
			pt.y    = clip32(acc[1]);
			pt.z    = clip32(acc[2]);
			pt.last = (k + 1 == np);
			queue_point(pt);
		end
	endtask

	// bookkeeping for an accepted row; a typed row means every point is the locus
	task automatic take_row(input row_t r, input bit typed);
		int unsigned np;
		point_t      pt;
		for (int a = 0; a < 6; a++) coef_mem[r.idx][a] = r.coef[a];
		if (!r.last) return;
		for (int a = 0; a < 3; a++) locus_mem[a] = r.loc[a];
		shapes_sent++;
		if (!typed) begin
			reconstruct_shape();
			return;
		end
		np = (pts_cfg > NPTS) ? NPTS : pts_cfg;
		for (int unsigned k = 0; k < np; k++) begin
			pt.idx  = k[PIDX_W-1:0];
			pt.x    = r.loc[0];
			pt.y    = r.loc[1];
			pt.z    = r.loc[2];
			pt.last = (k + 1 == np);
			queue_point(pt);
		end
	endtask

	task automatic send_row(input row_t r, input bit typed);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			rows.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rows.valid      <= 1'b1;
		rows.row_index  <= r.idx;
		rows.x_cos_coef <= r.coef[0];
		rows.x_sin_coef <= r.coef[1];
		rows.y_cos_coef <= r.coef[2];
		rows.y_sin_coef <= r.coef[3];
		rows.z_cos_coef <= r.coef[4];
		rows.z_sin_coef <= r.coef[5];
		rows.locus_x    <= r.loc[0];
		rows.locus_y    <= r.loc[1];
		rows.locus_z    <= r.loc[2];
		rows.last_row   <= r.last;
		do @(posedge clk); while (!rows.ready);
		take_row(r, typed);
	endtask

	// block idle: every point back, then the drain allowance
	task automatic settle();
		rows.valid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] p);
		wr_en    <= 1'b1;
		wr_index <= CFG_HARMONIC_COUNT;
		wr_data  <= h;
		@(posedge clk);
		harm_cfg = h[HCNT_W-1:0];
		wr_index <= CFG_POINT_COUNT;
		wr_data  <= p;
		@(posedge clk);
		pts_cfg = p[PCNT_W-1:0];
		wr_en <= 1'b0;
	endtask

	// full range, mid-size, tiny or zero coefficients
	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			2: return 32'($signed($urandom_range(0, 512)) - 256);
			default: return '0;
		endcase
	endfunction

	function automatic row_t rand_row(input logic [2:0] idx, input logic last);
		row_t r;
		r.idx  = idx;
		r.last = last;
		for (int a = 0; a < 6; a++) r.coef[a] = rand_coef();
		for (int a = 0; a < 3; a++) r.loc[a] = rand_coef();
		return r;
	endfunction

	// points side: random stalls, or none during calm phases
	initial begin
		int     stall;
		point_t got, want;
		@(posedge arst_n);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				points.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			points.ready <= 1'b1;
			do @(posedge clk); while (!points.valid);
			got = '{points.point_index, points.point_x, points.point_y,
				points.point_z, points.last_point};
			points_seen++;
			if (pending_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected point, none pending: actual %p", $time, got);
			end else begin
				want = pending_points.pop_front();
				if (got.idx !== want.idx) begin
					errors++;
					$display("%0t: point_index expected %0d actual %0d", $time, want.idx, got.idx);
				end
				if (got.x !== want.x) begin
					errors++;
					$display("%0t: point_x expected %0d actual %0d", $time, want.x, got.x);
				end
				if (got.y !== want.y) begin
					errors++;
					$display("%0t: point_y expected %0d actual %0d", $time, want.y, got.y);
				end
				if (got.z !== want.z) begin
					errors++;
					$display("%0t: point_z expected %0d actual %0d", $time, want.z, got.z);
				end
				if (got.last !== want.last) begin
					errors++;
					$display("%0t: last_point expected %0b actual %0b", $time, want.last,
						got.last);
				end
			end
		end
	end

	// overall watchdog
	initial begin
		#20_000_000;
		$display("FAIL elliptic_fourier_reconstruction");
		$finish;
	end

	initial begin
		typedef struct {
			bit                    cfg;
			logic [CFG_DATA_W-1:0] h;
			logic [CFG_DATA_W-1:0] p;
			bit                    typed;
			row_t                  r;
		} dir_t;
		dir_t                  dir [$];
		dir_t                  d;
		int                    items;
		int                    order [$];
		int                    heff, tmp, j;
		logic [CFG_DATA_W-1:0] hsel, psel;
		logic [COEF_W-1:0]     ext;

		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = '0;
		wr_data      = '0;
		rows.valid   = 1'b0;
		rows.row_index  = '0;
		rows.x_cos_coef = '0;
		rows.x_sin_coef = '0;
		rows.y_cos_coef = '0;
		rows.y_sin_coef = '0;
		rows.z_cos_coef = '0;
		rows.z_sin_coef = '0;
		rows.locus_x    = '0;
		rows.locus_y    = '0;
		rows.locus_z    = '0;
		rows.last_row   = 1'b0;
		points.ready = 1'b0;
		errors       = 0;
		points_seen  = 0;
		shapes_sent  = 0;
		items        = 0;
		src_calm     = 1'b0;
		sink_calm    = 1'b0;
		harm_cfg     = HCNT_RESET;
		pts_cfg      = PCNT_RESET;
		for (int a = 0; a < 3; a++) locus_mem[a] = '0;
		for (int q = 0; q <= QSIZE; q++) quarter_tbl[q] = quarter_sin_q30(q);

		// --- directed table ---
		// reset settings; every row written, row 0 all max, row 1 all min, last on row 7
		for (int n = 0; n < NHARM; n++) begin
			d = '{0, '0, '0, 0, rand_row(n[2:0], n == NHARM - 1)};
			ext = (n == 0) ? 32'h7fffffff : (n == 1) ? 32'h80000000 : 32'h0001_0000;
			for (int a = 0; a < 6; a++) d.r.coef[a] = ext;
			dir.insert(dir.size(), d);
		end
		// no harmonics, one point: the locus itself, at the extremes
		d = '{1, 7'd0, 7'd1, 1, rand_row(3'd0, 1'b1)};
		d.r.loc = {32'h80000000, 32'h7fffffff, 32'hffffffff};
		dir.insert(dir.size(), d);
		// harmonic count 16 wraps to 0 in 4 bits: still locus only, three points
		d = '{1, 7'h10, 7'd3, 1, rand_row(3'd5, 1'b1)};
		dir.insert(dir.size(), d);
		// both counts above their maxima: clamped to 8 harmonics, 64 points
		d = '{1, 7'd15, 7'd127, 0, rand_row(3'd7, 1'b1)};
		dir.insert(dir.size(), d);
		// point count zero: a last row that yields nothing
		d = '{1, 7'd1, 7'd0, 1, rand_row(3'd0, 1'b1)};
		dir.insert(dir.size(), d);
		// saturation: max locus plus max coefficients, two points
		d = '{1, 7'd8, 7'd2, 0, rand_row(3'd0, 1'b1)};
		d.r.coef = {6{32'h7fffffff}};
		d.r.loc  = {3{32'h7fffffff}};
		dir.insert(dir.size(), d);
		// negative saturation, all 64 points; 7'h19 keeps 9 in 4 bits -> clamp 8
		d = '{1, 7'h19, 7'd64, 0, rand_row(3'd2, 1'b1)};
		d.r.coef = {6{32'h80000000}};
		d.r.loc  = {3{32'h80000000}};
		dir.insert(dir.size(), d);
		// a plain row that is not last, then one harmonic
		d = '{1, 7'd1, 7'd5, 0, rand_row(3'd0, 1'b0)};
		dir.insert(dir.size(), d);
		d = '{0, '0, '0, 0, rand_row(3'd0, 1'b1)};
		dir.insert(dir.size(), d);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			if (dir[i].cfg) begin
				settle();
				set_config(dir[i].h, dir[i].p);
			end
			send_row(dir[i].r, dir[i].typed);
			items++;
		end

		// --- random shapes, grouped in settings phases ---
		while (items < NITEMS) begin
			settle();
			case ($urandom_range(0, 5))
				0: hsel = 7'd0;
				1: hsel = 7'd8;
				2: hsel = 7'd15;
				3: hsel = 7'($urandom_range(0, 127));
				default: hsel = 7'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 9))
				0: psel = 7'd0;
				1: psel = 7'd64;
				2: psel = 7'($urandom_range(65, 127));
				3: psel = 7'd1;
				default: psel = 7'($urandom_range(2, 12));
			endcase
			set_config(hsel, psel);
			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			heff = (harm_cfg > NHARM) ? NHARM : harm_cfg;
			repeat ($urandom_range(1, 4)) begin
				// mostly a full set of rows in shuffled order; now and then a bare last row
				if ($urandom_range(0, 9) != 0) begin
					order.delete();
					for (int n = 0; n < heff; n++) order.insert(order.size(), n);
					for (int n = heff - 1; n > 0; n--) begin
						j = $urandom_range(0, n);
						tmp = order[n];
						order[n] = order[j];
						order[j] = tmp;
					end
					repeat ($urandom_range(0, 2))
						order.insert(order.size(), int'($urandom_range(0, 7)));
					foreach (order[n]) begin
						send_row(rand_row(order[n][2:0], 1'b0), 0);
						items++;
					end
				end
				send_row(rand_row(3'($urandom_range(0, 7)), 1'b1), 0);
				items++;
			end
		end

		settle();
		$display("Sent %0d rows forming %0d shapes; %0d points checked, %0d mismatches.",
			items, shapes_sent, points_seen, errors);
		if (errors == 0)
			$display("PASS elliptic_fourier_reconstruction");
		else
			$display("FAIL elliptic_fourier_reconstruction");
		$finish;
	end

endmodule
